// File: sv/md4_pkg.sv
// ----------------------------------------------------------------------------
// md4_pkg
// shared types, constants and round functions of the md4 hash engine
// ----------------------------------------------------------------------------
package md4_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] K2     = 32'h5A827999;
   localparam logic [31:0] K3     = 32'h6ED9EBA1;

   localparam int          BLOCK_WORDS = 16;
   localparam logic [5:0]  POS_LAST    = 6'd63;
   localparam logic [5:0]  POS_LEN     = 6'd56;
   localparam logic [5:0]  STEP_LAST   = 6'd47;
   localparam logic [1:0]  IDX_LAST    = 2'd3;
   localparam logic [7:0]  PAD_MARK    = 8'h80;

   localparam logic        OP_ABSORB = 1'b0;
   localparam logic        OP_FINISH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMP,
      ST_FOLD,
      ST_EMIT
   } md4_state_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } md4_sel_type;

   typedef struct packed {
      logic        write_byte;
      md4_sel_type byte_sel;
      logic        save_len;
      logic        load_work;
      logic        step_en;
      logic [5:0]  step;
      logic        fold;
      logic        load_out;
      logic [1:0]  out_idx;
      logic        clear;
   } md4_cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic       out_free;
   } md4_status_type;

   // message word used at a step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] j;
      j = step[3:0];
      case (step[5:4])
         2'd0: begin
            msg_index = j;
         end
         2'd1: begin
            msg_index = {j[1:0], j[3:2]};
         end
         default: begin
            msg_index = {j[0], j[1], j[2], j[3]};
         end
      endcase
   endfunction

   // rotate amount of a step
   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      case ({step[5:4], step[1:0]})
         4'd0:    rot_amount = 5'd3;
         4'd1:    rot_amount = 5'd7;
         4'd2:    rot_amount = 5'd11;
         4'd3:    rot_amount = 5'd19;
         4'd4:    rot_amount = 5'd3;
         4'd5:    rot_amount = 5'd5;
         4'd6:    rot_amount = 5'd9;
         4'd7:    rot_amount = 5'd13;
         4'd8:    rot_amount = 5'd3;
         4'd9:    rot_amount = 5'd9;
         4'd10:   rot_amount = 5'd11;
         default: rot_amount = 5'd15;
      endcase
   endfunction

   // round function plus round constant
   function automatic logic [31:0] round_fk(input logic [1:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      case (rnd)
         2'd0: begin
            round_fk = (b & c) | (~b & d);
         end
         2'd1: begin
            round_fk = ((b & c) | (b & d) | (c & d)) + K2;
         end
         default: begin
            round_fk = (b ^ c ^ d) + K3;
         end
      endcase
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] w;
      w = {v, v} << s;
      rotl32 = w[63:32];
   endfunction

endpackage

// File: sv/md4_ctrl.sv
// ----------------------------------------------------------------------------
// md4_ctrl
// sequencer for byte absorb, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module md4_ctrl
   import md4_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_op,
   output logic           req_ready,
   input  md4_status_type status,
   output md4_cmd_type    cmd
);

   md4_state_type state_ff, state_in;
   md4_state_type ret_ff, ret_in;
   logic [5:0]    step_ff, step_in;
   logic [1:0]    idx_ff, idx_in;
   logic          accept;
   logic          block_full;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign block_full = (status.pos == POS_LAST);
   assign req_ready  = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_FINISH) begin
                  state_in = ST_PAD_MARK;
               end else if (block_full) begin
                  state_in = ST_COMP;
                  ret_in   = ST_IDLE;
               end
            end
         end
         ST_PAD_MARK: begin
            if (block_full) begin
               state_in = ST_COMP;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.pos == POS_LEN) begin
               state_in = ST_PAD_LEN;
            end else if (block_full) begin
               state_in = ST_COMP;
               ret_in   = ST_PAD_ZERO;
            end
         end
         ST_PAD_LEN: begin
            if (block_full) begin
               state_in = ST_COMP;
               ret_in   = ST_EMIT;
            end
         end
         ST_COMP: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_FOLD;
               step_in  = '0;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_FOLD: begin
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.byte_sel = SEL_DATA;
      cmd.step     = step_ff;
      cmd.out_idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_FINISH) begin
                  cmd.save_len = 1'b1;
               end else begin
                  cmd.write_byte = 1'b1;
                  cmd.load_work  = block_full;
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.write_byte = 1'b1;
            cmd.byte_sel   = SEL_MARK;
            cmd.load_work  = block_full;
         end
         ST_PAD_ZERO: begin
            if (status.pos != POS_LEN) begin
               cmd.write_byte = 1'b1;
               cmd.byte_sel   = SEL_ZERO;
               cmd.load_work  = block_full;
            end
         end
         ST_PAD_LEN: begin
            cmd.write_byte = 1'b1;
            cmd.byte_sel   = SEL_LEN;
            cmd.load_work  = block_full;
         end
         ST_COMP: begin
            cmd.step_en = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = (idx_ff == IDX_LAST);
            end
         end
         default: begin
            cmd.step = step_ff;
         end
      endcase
   end

endmodule

// File: sv/md4_dpath.sv
// ----------------------------------------------------------------------------
// md4_dpath
// block buffer, bit counter, chaining words, one-step round unit, output beat
// ----------------------------------------------------------------------------
module md4_dpath
   import md4_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  md4_cmd_type    cmd,
   input  logic [7:0]     data_byte,
   output md4_status_type status,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [31:0]    out_word,
   output logic [1:0]     out_index,
   output logic           out_last
);

   logic [31:0] buf_ff [BLOCK_WORDS];
   logic [31:0] chain_ff [4];
   logic [63:0] count_ff;
   logic [63:0] len_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic        valid_ff;
   logic [31:0] word_ff;
   logic [1:0]  index_ff;
   logic        last_ff;

   logic [5:0]  pos;
   logic [7:0]  wr_byte;
   logic [31:0] step_sum;
   logic [31:0] step_t;

   assign pos             = count_ff[8:3];
   assign status.pos      = pos;
   assign status.out_free = !valid_ff || out_ready;

   always_comb begin
      case (cmd.byte_sel)
         SEL_DATA: wr_byte = data_byte;
         SEL_MARK: wr_byte = PAD_MARK;
         SEL_ZERO: wr_byte = 8'h00;
         default:  wr_byte = len_ff[{pos[2:0], 3'b000} +: 8];
      endcase
   end

   assign step_sum = a_ff + round_fk(cmd.step[5:4], b_ff, c_ff, d_ff)
                     + buf_ff[msg_index(cmd.step)];
   assign step_t   = rotl32(step_sum, rot_amount(cmd.step));

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         buf_ff[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save_len) begin
         len_ff <= count_ff;
      end
      if (cmd.load_work) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (cmd.step_en) begin
         a_ff <= d_ff;
         b_ff <= step_t;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
         count_ff    <= '0;
      end else begin
         if (cmd.fold) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.write_byte) begin
            count_ff <= count_ff + 64'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         word_ff  <= chain_ff[cmd.out_idx];
         index_ff <= cmd.out_idx;
         last_ff  <= (cmd.out_idx == IDX_LAST);
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_index = index_ff;
   assign out_last  = last_ff;

endmodule

// File: sv/md4_hash_engine.sv
// ----------------------------------------------------------------------------
// md4_hash_engine
// streaming md4 message digest, one message byte per input beat
// ----------------------------------------------------------------------------
// req channel: tuser 0 absorbs the byte in tdata, tuser 1 finishes the
// message. req_tready is high only while the engine is idle.
// the absorb beat that fills a 64-byte block starts the compression (48
// single-step rounds of one shared round unit, then one add into the
// chaining words); req_tready stays low until it is done. a finish beat
// pads one byte per cycle outside compressions (up to 72 pad and length
// bytes plus a pass at the length boundary that writes none, with one or
// two compressions), then sends four digest beats on rsp (word 0 first, one
// per cycle unless rsp stalls, tlast on word 3) and holds the initial state.
// rsp is held in an output register: a stalled receiver freezes the digest
// beats, and absorb beats are still taken while the last digest beat waits.
// reset (synchronous, active high) loads the initial chaining words, clears
// the bit counter and drops rsp_tvalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module md4_hash_engine
   import md4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);

   md4_cmd_type    cmd;
   md4_status_type status;

   md4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   md4_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_tdata),
      .status    (status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata),
      .out_index (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the md4 hash engine against its own digest predictor. messages of
// assorted lengths, short ones and ones around the block and padding
// boundaries, stream in one byte per beat. each finish beat queues the four
// expected digest words, and every rsp beat is compared with the oldest
// queued word. both channels idle at random, and the receiver holds off for
// one long stretch so that the engine backs up into the req channel.
// ----------------------------------------------------------------------------
module testbench
   import md4_pkg::*;
();

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   class digest_scoreboard;
      logic [31:0]     chain[4];
      logic [31:0]     block[16];
      logic [63:0]     bit_total;
      digest_beat_type expected_words[$];
      int              mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = INIT_A;
         chain[1] = INIT_B;
         chain[2] = INIT_C;
         chain[3] = INIT_D;
         bit_total = '0;
      endfunction

      function void compress_block();
         int          rots[12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
         int          third_order[16] = '{0, 8, 4, 12, 2, 10, 6, 14,
                                          1, 9, 5, 13, 3, 11, 7, 15};
         logic [31:0] a, b, c, d, f, sum, t;
         int          rnd, j, w, n;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (int s = 0; s < 48; s++) begin
            rnd = s / 16;
            j = s % 16;
            case (rnd)
               0: begin
                  w = j;
                  f = (b & c) | (~b & d);
               end
               1: begin
                  w = (j % 4) * 4 + j / 4;
                  f = ((b & c) | (b & d) | (c & d)) + K2;
               end
               default: begin
                  w = third_order[j];
                  f = (b ^ c ^ d) + K3;
               end
            endcase
            n = rots[rnd * 4 + (s % 4)];
            sum = a + f + block[w];
            t = (sum << n) | (sum >> (32 - n));
            a = d;
            d = c;
            c = b;
            b = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      function void take_byte(logic [7:0] value);
         logic [5:0] pos;
         pos = bit_total[8:3];
         block[pos[5:2]][pos[1:0] * 8 +: 8] = value;
         bit_total += 64'd8;
         if (pos == 6'd63) compress_block();
      endfunction

      function void note_request(logic op, logic [7:0] data);
         logic [63:0]     length_bits;
         digest_beat_type beat;
         if (op == OP_ABSORB) begin
            take_byte(data);
            return;
         end
         length_bits = bit_total;
         take_byte(8'h80);
         while (bit_total[8:3] != 6'd56) take_byte(8'h00);
         for (int k = 0; k < 8; k++) take_byte(length_bits[8 * k +: 8]);
         for (int k = 0; k < 4; k++) begin
            beat.word = chain[k];
            beat.index = k[1:0];
            beat.last = (k == 3);
            expected_words.push_back(beat);
         end
         restart();
      endfunction

      function void check_response(logic [31:0] word, logic [1:0] index, logic last);
         digest_beat_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: word %h index %0d last %b", word, index, last);
            return;
         end
         want = expected_words.pop_front();
         if (word !== want.word || index !== want.index || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: expected word %h index %0d last %b, got %h %0d %b",
                        want.word, want.index, want.last, word, index, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   digest_scoreboard sb = new();
   int items_sent = 0;
   int responses_seen = 0;

   md4_hash_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic drive_beat(input logic op, input logic [7:0] data);
      if (!(items_sent >= 120 && items_sent < 200) && $urandom_range(0, 99) < 16) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) drive_beat(OP_ABSORB, 8'($urandom_range(0, 255)));
      drive_beat(OP_FINISH, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int boundary_lengths[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int len;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = OP_ABSORB;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty message
      drive_beat(OP_FINISH, 8'hff);
      // "abc"
      drive_beat(OP_ABSORB, 8'h61);
      drive_beat(OP_ABSORB, 8'h62);
      drive_beat(OP_ABSORB, 8'h63);
      drive_beat(OP_FINISH, 8'h00);
      // byte extremes
      drive_beat(OP_ABSORB, 8'h00);
      drive_beat(OP_ABSORB, 8'hff);
      drive_beat(OP_ABSORB, 8'h00);
      drive_beat(OP_ABSORB, 8'hff);
      drive_beat(OP_FINISH, 8'h00);

      while (items_sent < 300) begin
         if ($urandom_range(0, 3) == 0) len = boundary_lengths[$urandom_range(0, 9)];
         else len = $urandom_range(0, 24);
         if (len > 299 - items_sent) len = 299 - items_sent;
         send_message(len);
      end
      req_tvalid = 1'b0;

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // receiver, with one long hold-off once a couple of digests are through
   initial begin
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && responses_seen >= 8) begin
            rsp_tready = 1'b0;
            repeat (600) @(negedge clock);
            held = 1'b1;
         end
         if (responses_seen >= 24 && responses_seen < 48) rsp_tready = 1'b1;
         else rsp_tready = ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         responses_seen++;
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
